/* sv/stt_pkg.sv */
// Shared types, constants and character helpers of the source text tokenizer.
package stt_pkg;

   typedef enum logic [4:0] {
      MODE_NORMAL      = 5'd0,
      MODE_CMT_SELECT  = 5'd1,
      MODE_CMT_LINE    = 5'd2,
      MODE_CMT_BLOCK   = 5'd3,
      MODE_STRING      = 5'd4,
      MODE_STRING_ESC  = 5'd5,
      MODE_CHAR        = 5'd6,
      MODE_CHAR_ESC    = 5'd7,
      MODE_IDENT       = 5'd8,
      MODE_ZERO        = 5'd9,
      MODE_HEX         = 5'd10,
      MODE_BIN         = 5'd11,
      MODE_OCT         = 5'd12,
      MODE_DEC         = 5'd13,
      MODE_DEC_EXP     = 5'd14,
      MODE_DEC_SIGN    = 5'd15,
      MODE_DEC_FRAC    = 5'd16,
      MODE_DIRECTIVE   = 5'd17
   } mode_type;

   localparam logic [3:0] KIND_OP        = 4'd0;
   localparam logic [3:0] KIND_STRING    = 4'd1;
   localparam logic [3:0] KIND_CHAR      = 4'd2;
   localparam logic [3:0] KIND_IDENT     = 4'd3;
   localparam logic [3:0] KIND_DEC       = 4'd4;
   localparam logic [3:0] KIND_HEX       = 4'd5;
   localparam logic [3:0] KIND_BIN       = 4'd6;
   localparam logic [3:0] KIND_OCT       = 4'd7;
   localparam logic [3:0] KIND_FLOAT     = 4'd8;
   localparam logic [3:0] KIND_DIRECTIVE = 4'd9;
   localparam logic [3:0] KIND_EOF       = 4'd10;

   localparam logic EV_BYTE = 1'b0;
   localparam logic EV_END  = 1'b1;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_EOF  = 1'b1;

   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER     = 8'h5F;
   localparam logic [7:0] CH_NL        = 8'h0A;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_DOT       = 8'h2E;

   // Results per input item never exceed four.
   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic is_word(input logic [7:0] b);
      return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
   endfunction

   function automatic logic is_octal(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h37);
   endfunction

   function automatic logic is_hexd(input logic [7:0] b);
      return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] r;
      unique case (b)
         8'h61:   r = 8'd7;
         8'h62:   r = 8'd8;
         8'h66:   r = 8'd12;
         8'h6E:   r = 8'd10;
         8'h72:   r = 8'd13;
         8'h74:   r = 8'd9;
         8'h76:   r = 8'd11;
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

/* sv/stt_front.sv */
// Front end: classify each byte, update lexer state, build the result bundle.
module stt_front #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [7:0]          req_source_byte,
   input  stt_pkg::qstat_type  q_status,
   output logic                push,
   output logic [2 + stt_pkg::MAX_RESULTS * (13 + 2 * POSITION_BITS):0] push_data
);

   localparam int unsigned P = POSITION_BITS;

   typedef struct packed {
      logic         ev;
      logic [7:0]   tbyte;
      logic [3:0]   kind;
      logic [P-1:0] row;
      logic [P-1:0] col;
   } rec_type;

   function automatic rec_type mk_byte(input logic [7:0] b);
      rec_type r;
      r.ev    = stt_pkg::EV_BYTE;
      r.tbyte = b;
      r.kind  = stt_pkg::KIND_OP;
      r.row   = '0;
      r.col   = '0;
      return r;
   endfunction

   function automatic rec_type mk_end(input logic [3:0] k, input logic [P-1:0] row,
                                      input logic [P-1:0] col);
      rec_type r;
      r.ev    = stt_pkg::EV_END;
      r.tbyte = 8'd0;
      r.kind  = k;
      r.row   = row;
      r.col   = col;
      return r;
   endfunction

   stt_pkg::mode_type mode_ff, mode_in;
   logic              float_ff, float_in;
   logic              open_ff, open_in;
   logic [P-1:0]      tsr_ff, tsr_in, tsc_ff, tsc_in, row_ff, row_in, col_ff, col_in;

   rec_type [stt_pkg::MAX_RESULTS-1:0] recs;
   logic [2:0] cnt;
   logic       do_norm, do_tail, allow_dot;
   logic [7:0] b;
   logic       accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (cnt != 3'd0);
   assign push_data = {cnt, recs};

   always_comb begin
      mode_in   = mode_ff;
      float_in  = float_ff;
      open_in   = open_ff;
      tsr_in    = tsr_ff;
      tsc_in    = tsc_ff;
      row_in    = row_ff;
      col_in    = col_ff + {{(P-1){1'b0}}, 1'b1};
      recs      = '0;
      cnt       = 3'd0;
      do_norm   = 1'b0;
      do_tail   = 1'b0;
      allow_dot = 1'b1;
      b         = req_source_byte;
      if (req_kind == stt_pkg::REQ_EOF) begin
         if (open_ff) begin
            tsr_in = row_ff;
            tsc_in = col_in;
         end
         recs[0]  = mk_end(stt_pkg::KIND_EOF, tsr_in, tsc_in);
         cnt      = 3'd1;
         mode_in  = stt_pkg::MODE_NORMAL;
         float_in = 1'b0;
         open_in  = 1'b1;
      end else begin
         unique case (mode_ff)
            stt_pkg::MODE_NORMAL: do_norm = 1'b1;
            stt_pkg::MODE_CMT_SELECT:
               mode_in = (b == stt_pkg::CH_HASH) ? stt_pkg::MODE_CMT_LINE
                                                 : stt_pkg::MODE_CMT_BLOCK;
            stt_pkg::MODE_CMT_LINE: begin
               if (b == stt_pkg::CH_NL) begin
                  row_in  = row_ff + {{(P-1){1'b0}}, 1'b1};
                  col_in  = '0;
                  mode_in = stt_pkg::MODE_NORMAL;
               end
            end
            stt_pkg::MODE_CMT_BLOCK: begin
               if (b == stt_pkg::CH_NL) begin
                  row_in = row_ff + {{(P-1){1'b0}}, 1'b1};
                  col_in = '0;
               end else if (b == stt_pkg::CH_HASH) begin
                  mode_in = stt_pkg::MODE_NORMAL;
               end
            end
            stt_pkg::MODE_STRING, stt_pkg::MODE_CHAR: begin
               if ((mode_ff == stt_pkg::MODE_STRING && b == stt_pkg::CH_DQUOTE) ||
                   (mode_ff == stt_pkg::MODE_CHAR && b == stt_pkg::CH_SQUOTE)) begin
                  recs[0]  = mk_end((mode_ff == stt_pkg::MODE_STRING) ? stt_pkg::KIND_STRING
                                    : stt_pkg::KIND_CHAR, tsr_ff, tsc_ff);
                  cnt      = 3'd1;
                  mode_in  = stt_pkg::MODE_NORMAL;
                  float_in = 1'b0;
                  open_in  = 1'b1;
               end else if (b == stt_pkg::CH_NL) begin
                  row_in = row_ff + {{(P-1){1'b0}}, 1'b1};
                  col_in = '0;
               end else if (b == stt_pkg::CH_BACKSLASH) begin
                  mode_in = (mode_ff == stt_pkg::MODE_STRING) ? stt_pkg::MODE_STRING_ESC
                                                              : stt_pkg::MODE_CHAR_ESC;
               end else begin
                  recs[0] = mk_byte(b);
                  cnt     = 3'd1;
               end
            end
            stt_pkg::MODE_STRING_ESC, stt_pkg::MODE_CHAR_ESC: begin
               recs[0] = mk_byte(stt_pkg::unescape(b));
               cnt     = 3'd1;
               mode_in = (mode_ff == stt_pkg::MODE_STRING_ESC) ? stt_pkg::MODE_STRING
                                                               : stt_pkg::MODE_CHAR;
            end
            stt_pkg::MODE_IDENT, stt_pkg::MODE_DIRECTIVE: begin
               if (!stt_pkg::is_word(b)) begin
                  recs[0]  = mk_end((mode_ff == stt_pkg::MODE_IDENT) ? stt_pkg::KIND_IDENT
                                    : stt_pkg::KIND_DIRECTIVE, tsr_ff, tsc_ff);
                  cnt      = 3'd1;
                  mode_in  = stt_pkg::MODE_NORMAL;
                  float_in = 1'b0;
                  open_in  = 1'b1;
                  do_norm  = 1'b1;
               end else begin
                  recs[0] = mk_byte(b);
                  cnt     = 3'd1;
               end
            end
            stt_pkg::MODE_ZERO: begin
               if (b == 8'h78 || b == 8'h58) begin
                  mode_in = stt_pkg::MODE_HEX;
               end else if (b == 8'h62 || b == 8'h42) begin
                  mode_in = stt_pkg::MODE_BIN;
               end else if (stt_pkg::is_octal(b)) begin
                  recs[0] = mk_byte(stt_pkg::CH_ZERO);
                  recs[1] = mk_byte(b);
                  cnt     = 3'd2;
                  mode_in = stt_pkg::MODE_OCT;
               end else if (b == stt_pkg::CH_DOT || stt_pkg::is_digit(b)) begin
                  recs[0] = mk_byte(stt_pkg::CH_ZERO);
                  recs[1] = mk_byte(b);
                  cnt     = 3'd2;
                  if (b == stt_pkg::CH_DOT) float_in = 1'b1;
                  mode_in = stt_pkg::MODE_DEC;
               end else begin
                  recs[0]  = mk_byte(stt_pkg::CH_ZERO);
                  recs[1]  = mk_end(stt_pkg::KIND_DEC, tsr_ff, tsc_ff);
                  cnt      = 3'd2;
                  mode_in  = stt_pkg::MODE_NORMAL;
                  float_in = 1'b0;
                  open_in  = 1'b1;
                  do_norm  = 1'b1;
               end
            end
            stt_pkg::MODE_HEX, stt_pkg::MODE_BIN, stt_pkg::MODE_OCT: begin
               if ((mode_ff == stt_pkg::MODE_HEX && !stt_pkg::is_hexd(b)) ||
                   (mode_ff == stt_pkg::MODE_BIN && b != 8'h30 && b != 8'h31) ||
                   (mode_ff == stt_pkg::MODE_OCT && !stt_pkg::is_octal(b))) begin
                  recs[0]  = mk_end((mode_ff == stt_pkg::MODE_HEX) ? stt_pkg::KIND_HEX :
                                    (mode_ff == stt_pkg::MODE_BIN) ? stt_pkg::KIND_BIN :
                                    stt_pkg::KIND_OCT, tsr_ff, tsc_ff);
                  cnt      = 3'd1;
                  mode_in  = stt_pkg::MODE_NORMAL;
                  float_in = 1'b0;
                  open_in  = 1'b1;
                  do_norm  = 1'b1;
               end else begin
                  recs[0] = mk_byte(b);
                  cnt     = 3'd1;
               end
            end
            stt_pkg::MODE_DEC: begin
               if (b == 8'h65 || b == 8'h45) begin
                  recs[0] = mk_byte(b);
                  cnt     = 3'd1;
                  mode_in = stt_pkg::MODE_DEC_EXP;
               end else begin
                  do_tail = 1'b1;
               end
            end
            stt_pkg::MODE_DEC_EXP: begin
               if (b == 8'h2B || b == 8'h2D) begin
                  recs[0] = mk_byte(b);
                  cnt     = 3'd1;
                  mode_in = stt_pkg::MODE_DEC_SIGN;
               end else begin
                  do_tail = 1'b1;
               end
            end
            stt_pkg::MODE_DEC_SIGN: do_tail = 1'b1;
            stt_pkg::MODE_DEC_FRAC: begin
               do_tail   = 1'b1;
               allow_dot = 1'b0;
            end
            default: begin
               mode_in = stt_pkg::MODE_NORMAL;
               do_norm = 1'b1;
            end
         endcase

         // Digit tail shared by the decimal substates.
         if (do_tail) begin
            if (allow_dot && b == stt_pkg::CH_DOT) begin
               float_in = 1'b1;
               recs[0]  = mk_byte(b);
               cnt      = 3'd1;
               mode_in  = stt_pkg::MODE_DEC_FRAC;
            end else if (!stt_pkg::is_digit(b)) begin
               recs[0]  = mk_end(float_ff ? stt_pkg::KIND_FLOAT : stt_pkg::KIND_DEC,
                                 tsr_ff, tsc_ff);
               cnt      = 3'd1;
               mode_in  = stt_pkg::MODE_NORMAL;
               float_in = 1'b0;
               open_in  = 1'b1;
               do_norm  = 1'b1;
            end else begin
               recs[0] = mk_byte(b);
               cnt     = 3'd1;
               mode_in = stt_pkg::MODE_DEC;
            end
         end

         // Normal state, also the second pass of a terminating byte.
         if (do_norm) begin
            if (open_in) begin
               tsr_in  = row_in;
               tsc_in  = col_in;
               open_in = 1'b0;
            end
            if (b <= stt_pkg::CH_SPACE) begin
               if (b == stt_pkg::CH_NL) begin
                  row_in = row_in + {{(P-1){1'b0}}, 1'b1};
                  col_in = '0;
               end
            end else if (b == stt_pkg::CH_HASH) begin
               mode_in = stt_pkg::MODE_CMT_SELECT;
            end else begin
               tsr_in = row_in;
               tsc_in = col_in;
               if (b == stt_pkg::CH_ZERO) begin
                  mode_in = stt_pkg::MODE_ZERO;
               end else if (stt_pkg::is_digit(b)) begin
                  recs[cnt[1:0]] = mk_byte(b);
                  cnt            = cnt + 3'd1;
                  mode_in        = stt_pkg::MODE_DEC;
               end else if (stt_pkg::is_word(b)) begin
                  recs[cnt[1:0]] = mk_byte(b);
                  cnt            = cnt + 3'd1;
                  mode_in        = stt_pkg::MODE_IDENT;
               end else if (b == stt_pkg::CH_DQUOTE) begin
                  mode_in = stt_pkg::MODE_STRING;
               end else if (b == stt_pkg::CH_SQUOTE) begin
                  mode_in = stt_pkg::MODE_CHAR;
               end else if (b == stt_pkg::CH_BACKSLASH) begin
                  mode_in = stt_pkg::MODE_DIRECTIVE;
               end else begin
                  recs[cnt[1:0]] = mk_byte(b);
                  cnt            = cnt + 3'd1;
                  recs[cnt[1:0]] = mk_end(stt_pkg::KIND_OP, tsr_in, tsc_in);
                  cnt            = cnt + 3'd1;
                  mode_in        = stt_pkg::MODE_NORMAL;
                  float_in       = 1'b0;
                  open_in        = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stt_pkg::MODE_NORMAL;
         float_ff <= 1'b0;
         open_ff  <= 1'b1;
         tsr_ff   <= '0;
         tsc_ff   <= '0;
         row_ff   <= {{(P-1){1'b0}}, 1'b1};
         col_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         float_ff <= float_in;
         open_ff  <= open_in;
         tsr_ff   <= tsr_in;
         tsc_ff   <= tsc_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

endmodule

/* sv/stt_queue.sv */
// Short bundle queue between the front and back ends.
module stt_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   push_data,
   input  logic               pop,
   output logic [WIDTH-1:0]   head_data,
   output stt_pkg::qstat_type q_status
);

   localparam int unsigned DEPTH = stt_pkg::QUEUE_DEPTH;
   localparam int unsigned AW    = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [AW:0]      count_ff;

   assign q_status.full  = (count_ff == (AW+1)'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_data      = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + {{(AW-1){1'b0}}, 1'b1};
         if (pop)  rd_ff <= rd_ff + {{(AW-1){1'b0}}, 1'b1};
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + {{AW{1'b0}}, 1'b1};
            2'b01:   count_ff <= count_ff - {{AW{1'b0}}, 1'b1};
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* sv/stt_back.sv */
// Back end: walk each bundle one result at a time into the output register.
module stt_back #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  stt_pkg::qstat_type  q_status,
   input  logic [2 + stt_pkg::MAX_RESULTS * (13 + 2 * POSITION_BITS):0] head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_event_res,
   output logic [7:0]          rsp_token_byte,
   output logic [3:0]          rsp_token_kind,
   output logic [POSITION_BITS-1:0] rsp_start_row,
   output logic [POSITION_BITS-1:0] rsp_start_column,
   output logic                rsp_last
);

   localparam int unsigned P = POSITION_BITS;

   typedef struct packed {
      logic         ev;
      logic [7:0]   tbyte;
      logic [3:0]   kind;
      logic [P-1:0] row;
      logic [P-1:0] col;
   } rec_type;

   rec_type [stt_pkg::MAX_RESULTS-1:0] recs;
   logic [2:0] cnt;
   logic [1:0] idx_ff;
   logic       load, at_end;
   logic       valid_ff;
   rec_type    out_ff;
   logic       last_ff;

   assign {cnt, recs} = head_data;
   assign load   = !q_status.empty && (!valid_ff || rsp_ready);
   assign at_end = ({1'b0, idx_ff} == (cnt - 3'd1));
   assign pop    = load && at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= at_end ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff  <= recs[idx_ff];
         last_ff <= at_end;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_res    = out_ff.ev;
   assign rsp_token_byte   = out_ff.tbyte;
   assign rsp_token_kind   = out_ff.kind;
   assign rsp_start_row    = out_ff.row;
   assign rsp_start_column = out_ff.col;
   assign rsp_last         = last_ff;

endmodule

/* sv/source_text_tokenizer.sv */
// Top level of the source text tokenizer: front end, bundle queue, back end.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    req_kind, req_source_byte
//   rsp_      out         rsp_valid/rsp_ready    event, byte, kind, row, column, last
//
// The front end takes one byte per cycle and turns it, in the same cycle, into a
// bundle of zero to four results. The back end moves one result per cycle out of
// its output register while the sink is ready and the queue holds a bundle; a
// four-entry bundle queue absorbs the bursts at token boundaries. Input stalls
// only when the queue is full.
// Reset is synchronous and active high; it empties the queue and output register
// and puts the lexer back in its normal state at row 1, column 0.
module source_text_tokenizer #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic [7:0]               req_source_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_event_res,
   output logic [7:0]               rsp_token_byte,
   output logic [3:0]               rsp_token_kind,
   output logic [POSITION_BITS-1:0] rsp_start_row,
   output logic [POSITION_BITS-1:0] rsp_start_column,
   output logic                     rsp_last
);

   // One bundle: result count plus four result records.
   localparam int unsigned BUNDLE_W = 3 + stt_pkg::MAX_RESULTS * (13 + 2 * POSITION_BITS);

   stt_pkg::qstat_type  q_status;
   logic                push, pop;
   logic [BUNDLE_W-1:0] push_data, head_data;

   // Classify bytes and advance lexer state on every input transfer.
   stt_front #(.POSITION_BITS(POSITION_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_source_byte (req_source_byte),
      .q_status        (q_status),
      .push            (push),
      .push_data       (push_data)
   );

   // Hold bundles until the back end drains them.
   stt_queue #(.WIDTH(BUNDLE_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .q_status  (q_status)
   );

   // Drop one result per output transfer; mark the last of each bundle.
   stt_back #(.POSITION_BITS(POSITION_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head_data        (head_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_token_byte   (rsp_token_byte),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_row    (rsp_start_row),
      .rsp_start_column (rsp_start_column),
      .rsp_last         (rsp_last)
   );

endmodule

/* sv/stt_checker.sv */
// Port-level checks of the source text tokenizer and their bind.
module stt_checker #(
   parameter int unsigned POSITION_BITS = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_kind,
   input logic [7:0]               req_source_byte,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_event_res,
   input logic [7:0]               rsp_token_byte,
   input logic [3:0]               rsp_token_kind,
   input logic [POSITION_BITS-1:0] rsp_start_row,
   input logic [POSITION_BITS-1:0] rsp_start_column,
   input logic                     rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_byte)
         && $stable(rsp_token_kind) && $stable(rsp_last) && $stable(rsp_start_column))
      else $error("result changed while stalled");

   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == stt_pkg::EV_BYTE |->
         rsp_token_kind == stt_pkg::KIND_OP && rsp_start_row == '0 && rsp_start_column == '0)
      else $error("byte transfer carries token end fields");

   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == stt_pkg::EV_END |-> rsp_token_byte == 8'd0)
      else $error("token end carries a byte");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == stt_pkg::KIND_EOF |->
         rsp_event_res == stt_pkg::EV_END && rsp_last)
      else $error("end of input not a final token end");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind source_text_tokenizer stt_checker #(.POSITION_BITS(POSITION_BITS)) u_stt_checker (.*);

/* bench/tb_source_text_tokenizer.sv */
// Self-checking bench for the source text tokenizer: stimulus, predictor, scoreboard.
module tb_source_text_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic       ev;
      logic [7:0] tbyte;
      logic [3:0] tkind;
      logic [15:0] row;
      logic [15:0] col;
      logic       last;
   } token_event_type;

   int fail_count = 0;

   // Print one line per mismatch and count it.
   task automatic report(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   // Scoreboard: predicts the token stream for each transfer and checks results.
   class token_scoreboard;
      stt_pkg::mode_type mode;
      bit          is_float;
      bit          scan_open;
      logic [15:0] start_row, start_col, cur_row, cur_col;
      token_event_type pending[$];
      token_event_type burst[$];
      int checked;

      function new();
         mode = stt_pkg::MODE_NORMAL; is_float = 0; scan_open = 1;
         start_row = 0; start_col = 0; cur_row = 1; cur_col = 0; checked = 0;
      endfunction

      function void put(logic ev, logic [7:0] b, logic [3:0] k, logic [15:0] r, logic [15:0] c);
         token_event_type t;
         t.ev = ev; t.tbyte = b; t.tkind = k; t.row = r; t.col = c; t.last = 0;
         if (burst.size() < 4) burst.push_back(t);
      endfunction

      function void emit(logic [7:0] b);
         put(stt_pkg::EV_BYTE, b, stt_pkg::KIND_OP, 16'd0, 16'd0);
      endfunction

      function void close_token(logic [3:0] k);
         put(stt_pkg::EV_END, 8'd0, k, start_row, start_col);
         mode = stt_pkg::MODE_NORMAL; is_float = 0; scan_open = 1;
      endfunction

      function void mark(); start_row = cur_row; start_col = cur_col; endfunction
      function void newline(); cur_col = 16'd0; cur_row = cur_row + 16'd1; endfunction

      function bit digit(logic [7:0] b); return b >= "0" && b <= "9"; endfunction
      function bit alpha(logic [7:0] b);
         return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
      endfunction
      function bit wordch(logic [7:0] b);
         return alpha(b) || digit(b) || b == stt_pkg::CH_UNDER;
      endfunction
      function bit octal(logic [7:0] b); return b >= "0" && b <= "7"; endfunction
      function bit hexd(logic [7:0] b);
         return digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
      endfunction

      function logic [7:0] map_escape(logic [7:0] b);
         case (b)
            "a": return 8'd7;
            "b": return 8'd8;
            "f": return 8'd12;
            "n": return 8'd10;
            "r": return 8'd13;
            "t": return 8'd9;
            "v": return 8'd11;
            default: return b;
         endcase
      endfunction

      // Digit tail of a decimal; returns 1 when the byte is to be lexed again.
      function bit dec_digits(logic [7:0] b, bit dot_ok);
         if (dot_ok && b == stt_pkg::CH_DOT) begin
            is_float = 1; emit(b); mode = stt_pkg::MODE_DEC_FRAC; return 0;
         end
         if (!digit(b)) begin
            close_token(is_float ? stt_pkg::KIND_FLOAT : stt_pkg::KIND_DEC); return 1;
         end
         emit(b); mode = stt_pkg::MODE_DEC; return 0;
      endfunction

      function bit lex_byte(logic [7:0] b);
         case (mode)
            stt_pkg::MODE_NORMAL: begin
               if (scan_open) begin mark(); scan_open = 0; end
               if (b <= stt_pkg::CH_SPACE) begin
                  if (b == stt_pkg::CH_NL) newline();
               end else if (b == stt_pkg::CH_ZERO) begin
                  mark(); mode = stt_pkg::MODE_ZERO;
               end else if (digit(b)) begin
                  mark(); emit(b); mode = stt_pkg::MODE_DEC;
               end else if (wordch(b)) begin
                  mark(); emit(b); mode = stt_pkg::MODE_IDENT;
               end else if (b == stt_pkg::CH_HASH) mode = stt_pkg::MODE_CMT_SELECT;
               else if (b == stt_pkg::CH_DQUOTE) begin
                  mark(); mode = stt_pkg::MODE_STRING;
               end else if (b == stt_pkg::CH_SQUOTE) begin
                  mark(); mode = stt_pkg::MODE_CHAR;
               end else if (b == stt_pkg::CH_BACKSLASH) begin
                  mark(); mode = stt_pkg::MODE_DIRECTIVE;
               end else begin
                  mark(); emit(b); close_token(stt_pkg::KIND_OP);
               end
               return 0;
            end
            stt_pkg::MODE_CMT_SELECT: begin
               mode = (b == stt_pkg::CH_HASH) ? stt_pkg::MODE_CMT_LINE
                                              : stt_pkg::MODE_CMT_BLOCK;
               return 0;
            end
            stt_pkg::MODE_CMT_LINE: begin
               if (b == stt_pkg::CH_NL) begin newline(); mode = stt_pkg::MODE_NORMAL; end
               return 0;
            end
            stt_pkg::MODE_CMT_BLOCK: begin
               if (b == stt_pkg::CH_NL) newline();
               else if (b == stt_pkg::CH_HASH) mode = stt_pkg::MODE_NORMAL;
               return 0;
            end
            stt_pkg::MODE_STRING, stt_pkg::MODE_CHAR: begin
               if (b == ((mode == stt_pkg::MODE_STRING) ? stt_pkg::CH_DQUOTE
                                                        : stt_pkg::CH_SQUOTE))
                  close_token(mode == stt_pkg::MODE_STRING ? stt_pkg::KIND_STRING
                                                           : stt_pkg::KIND_CHAR);
               else if (b == stt_pkg::CH_NL) newline();
               else if (b == stt_pkg::CH_BACKSLASH)
                  mode = (mode == stt_pkg::MODE_STRING) ? stt_pkg::MODE_STRING_ESC
                                                        : stt_pkg::MODE_CHAR_ESC;
               else emit(b);
               return 0;
            end
            stt_pkg::MODE_STRING_ESC, stt_pkg::MODE_CHAR_ESC: begin
               emit(map_escape(b));
               mode = (mode == stt_pkg::MODE_STRING_ESC) ? stt_pkg::MODE_STRING
                                                         : stt_pkg::MODE_CHAR;
               return 0;
            end
            stt_pkg::MODE_IDENT, stt_pkg::MODE_DIRECTIVE: begin
               if (!wordch(b)) begin
                  close_token(mode == stt_pkg::MODE_IDENT ? stt_pkg::KIND_IDENT
                                                          : stt_pkg::KIND_DIRECTIVE);
                  return 1;
               end
               emit(b); return 0;
            end
            stt_pkg::MODE_ZERO: begin
               if (b == "x" || b == "X") mode = stt_pkg::MODE_HEX;
               else if (b == "b" || b == "B") mode = stt_pkg::MODE_BIN;
               else if (octal(b)) begin
                  emit(stt_pkg::CH_ZERO); emit(b); mode = stt_pkg::MODE_OCT;
               end else if (b == stt_pkg::CH_DOT) begin
                  emit(stt_pkg::CH_ZERO); emit(b); is_float = 1; mode = stt_pkg::MODE_DEC;
               end else if (digit(b)) begin
                  emit(stt_pkg::CH_ZERO); emit(b); mode = stt_pkg::MODE_DEC;
               end else begin
                  emit(stt_pkg::CH_ZERO); close_token(stt_pkg::KIND_DEC); return 1;
               end
               return 0;
            end
            stt_pkg::MODE_HEX: begin
               if (!hexd(b)) begin close_token(stt_pkg::KIND_HEX); return 1; end
               emit(b); return 0;
            end
            stt_pkg::MODE_BIN: begin
               if (b != "0" && b != "1") begin close_token(stt_pkg::KIND_BIN); return 1; end
               emit(b); return 0;
            end
            stt_pkg::MODE_OCT: begin
               if (!octal(b)) begin close_token(stt_pkg::KIND_OCT); return 1; end
               emit(b); return 0;
            end
            stt_pkg::MODE_DEC: begin
               if (b == "e" || b == "E") begin
                  emit(b); mode = stt_pkg::MODE_DEC_EXP; return 0;
               end
               return dec_digits(b, 1);
            end
            stt_pkg::MODE_DEC_EXP: begin
               if (b == "+" || b == "-") begin
                  emit(b); mode = stt_pkg::MODE_DEC_SIGN; return 0;
               end
               return dec_digits(b, 1);
            end
            stt_pkg::MODE_DEC_SIGN: return dec_digits(b, 1);
            stt_pkg::MODE_DEC_FRAC: return dec_digits(b, 0);
            default: begin mode = stt_pkg::MODE_NORMAL; return 1; end
         endcase
      endfunction

      // Note an accepted input transfer and queue the events it must cause.
      function void note_input(logic kind, logic [7:0] b);
         burst.delete();
         cur_col = cur_col + 16'd1;
         if (kind == stt_pkg::REQ_EOF) begin
            if (scan_open) mark();
            put(stt_pkg::EV_END, 8'd0, stt_pkg::KIND_EOF, start_row, start_col);
            mode = stt_pkg::MODE_NORMAL; is_float = 0; scan_open = 1;
         end else begin
            for (int p = 0; p < 3; p++) if (!lex_byte(b)) break;
         end
         if (burst.size() > 0) burst[burst.size()-1].last = 1;
         foreach (burst[i]) pending.push_back(burst[i]);
      endfunction

      // Compare one result transfer with the oldest expected event.
      task check_result(token_event_type got);
         token_event_type exp_ev;
         if (pending.size() == 0) begin
            report("result arrived with nothing expected"); return;
         end
         exp_ev = pending.pop_front();
         checked++;
         if (got.ev !== exp_ev.ev) report($sformatf("event %0b, want %0b", got.ev, exp_ev.ev));
         if (got.tbyte !== exp_ev.tbyte)
            report($sformatf("token_byte %h, want %h", got.tbyte, exp_ev.tbyte));
         if (got.tkind !== exp_ev.tkind)
            report($sformatf("token_kind %0d, want %0d", got.tkind, exp_ev.tkind));
         if (got.row !== exp_ev.row) report($sformatf("row %0d, want %0d", got.row, exp_ev.row));
         if (got.col !== exp_ev.col)
            report($sformatf("column %0d, want %0d", got.col, exp_ev.col));
         if (got.last !== exp_ev.last)
            report($sformatf("last %0b, want %0b", got.last, exp_ev.last));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_kind = 0;
   logic [7:0]  req_source_byte = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_event_res;
   logic [7:0]  rsp_token_byte;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_start_row;
   logic [15:0] rsp_start_column;
   logic        rsp_last;

   source_text_tokenizer #(.POSITION_BITS(16)) DUT (.*);

   token_scoreboard tokens = new();
   int  sent = 0;
   bit  hold_off = 0;   // sink stalls completely while set

   initial forever #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Offer one item after a random gap; hold it until the transfer happens.
   task automatic send_item(input logic kind, input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1; req_kind <= kind; req_source_byte <= b;
      do @(posedge clock); while (!req_ready);
      tokens.note_input(kind, b);
      sent++;
   endtask

   // Drop valid and wait for the next clock edge.
   task automatic idle_input();
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_item(stt_pkg::REQ_BYTE, s[i]);
   endtask

   // Random text built from fixed fragments, with some noise bytes and end-of-input items.
   task automatic send_fragment();
      string frags[] = '{"abc_9 ", "0x1F+", "0b101;", "017 ", "0.5e", "12e+3.4 ",
                         "\"s\\n\\q\"", "'\\t'", "\\dir(", "## c\n", "#x blk # ",
                         "3.x", "0X", "09.", "\n", "1E-7"};
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) send_text(frags[$urandom_range(0, frags.size()-1)]);
      else if (pick < 9) send_item(stt_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
      else send_item(stt_pkg::REQ_EOF, 8'($urandom_range(0, 255)));
   endtask

   // Sink: random stalls per result, plus forced hold-off stretches.
   initial begin
      token_event_type got;
      int wait_cycles;
      @(negedge reset);
      forever begin
         wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
         if (wait_cycles > 0 || hold_off) begin
            rsp_ready <= 0;
            repeat (wait_cycles) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         got.ev = rsp_event_res; got.tbyte = rsp_token_byte; got.tkind = rsp_token_kind;
         got.row = rsp_start_row; got.col = rsp_start_column; got.last = rsp_last;
         tokens.check_result(got);
      end
   end

   // Hold the sink off for a long stretch while the source keeps offering.
   initial begin
      @(negedge reset);
      repeat (300) @(posedge clock);
      hold_off <= 1;
      repeat (120) @(posedge clock);
      hold_off <= 0;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: numbers, prefixes, exponent, escapes, comments, operators, end of input.
      send_text("0x9aF 0b1020 0777 0.25e-3 00 7e+ ab_Z9");
      send_item(stt_pkg::REQ_EOF, 8'hFF);
      send_text("\"a\\\n\\v\"'\\\\'\\pp ##\n#\n#");
      send_item(stt_pkg::REQ_BYTE, 8'hFF);
      send_item(stt_pkg::REQ_BYTE, 8'h00);
      send_item(stt_pkg::REQ_BYTE, 8'h7F);
      send_text("1.");
      send_item(stt_pkg::REQ_EOF, 8'h00);
      idle_input();
      // Pause until every expected result has come.
      while (tokens.pending.size() != 0) @(posedge clock);
      while (sent < 175) send_fragment();
      send_item(stt_pkg::REQ_EOF, 8'h00);
      idle_input();
      while (tokens.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d items and checked %0d token events, with stalls on both sides.",
               sent, tokens.checked);
      if (fail_count == 0 && tokens.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
